// ===== src/atup_pkg.sv =====
// Package for the ASCII-to-unsigned parser: widths, character codes,
// the token passed from the front end to the back end, and its class codes.
// No dependencies; every other file depends on this package.
package atup_pkg;

	localparam int POS_WIDTH  = 16;
	localparam int CH_W       = 8;
	localparam int VAL_W      = 64;
	localparam int CNT_W      = 16;
	localparam int BASE_W     = 6;
	localparam int DIG_W      = 6;
	localparam int MUL_W      = VAL_W + BASE_W;
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [BASE_W-1:0] RADIX_RST = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_DEC  = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_OCT  = BASE_W'(8);
	localparam logic [BASE_W-1:0] BASE_HEX  = BASE_W'(16);
	localparam logic [BASE_W-1:0] BASE_BIN  = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);

	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CH_W-1:0] CH_UP_B  = 8'h42;
	localparam logic [CH_W-1:0] CH_LO_B  = 8'h62;
	localparam logic [CH_W-1:0] UP_OFS   = CH_UP_A - 8'd10;
	localparam logic [CH_W-1:0] LO_OFS   = CH_LO_A - 8'd10;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_MINUS,
		CLS_PLUS,
		CLS_ZERO,
		CLS_X,
		CLS_B,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		logic              first;
		logic [BASE_W-1:0] radix;
		cls_t              cls;
		logic              is_digit;
		logic [DIG_W-1:0]  dval;
	} tok_t;

endpackage

// ===== src/atup_if.sv =====
// Channel interfaces of the ASCII-to-unsigned parser: character words in,
// result words out, each with valid/ready. Depends on atup_pkg.
interface atup_in_if;
	logic                    valid;
	logic                    ready;
	logic [atup_pkg::CH_W-1:0] ch;
	logic                    first;

	modport source (output valid, output ch, output first, input ready);
	modport sink   (input valid, input ch, input first, output ready);
endinterface

interface atup_out_if;
	logic                       valid;
	logic                       ready;
	logic [atup_pkg::VAL_W-1:0] value;
	logic [atup_pkg::CNT_W-1:0] consumed;
	logic                       no_digits;
	logic                       overflowed;

	modport source (output valid, output value, output consumed, output no_digits,
		output overflowed, input ready);
	modport sink   (input valid, input value, input consumed, input no_digits,
		input overflowed, output ready);
endinterface

// ===== src/ascii_to_unsigned_parser.sv =====
// Top level of the ASCII-to-unsigned parser: front end, token queue and
// back end. Depends on atup_pkg, atup_if, atup_front, atup_fifo, atup_back.
//
//   port      dir   word                                  handshake
//   chars     in    ch[7:0], first                        valid/ready
//   result    out   value[63:0], consumed[15:0],          valid/ready
//                   no_digits, overflowed
//   cfg_*     in    radix[5:0] (cfg_wdata)                cfg_we, no wait
//
// One character word per cycle, back to back, while the queue has room. The
// queue is written at the edge that accepts the terminating character, and the
// result register loads when the back end takes that token from the queue;
// tokens still waiting ahead of it in the queue are taken first.
// The rate is set by the accumulator loop: one multiply-add of the 64-bit value
// by the 6-bit base per cycle in the back end, while the result register is free.
// arst_n clears the queue, the parse state (idle, nothing pending) and the
// result register, and sets radix to 10.
// A stalled result only blocks the back end; the two-entry queue keeps
// taking characters until it fills, then chars.ready drops.
module ascii_to_unsigned_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [atup_pkg::BASE_W-1:0] cfg_wdata,
	atup_in_if.sink                     chars,
	atup_out_if.source                  result
);
	import atup_pkg::*;

	// front to queue
	logic push_valid;
	logic push_ready;
	tok_t push_tok;

	// queue to back end
	logic pop_valid;
	logic pop;
	tok_t pop_tok;

	// classify characters and latch the radix with each token
	atup_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.chars      (chars),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_tok   (push_tok)
	);

	// decouple: hold tokens while the result side stalls
	atup_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_tok   (push_tok),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_tok    (pop_tok)
	);

	// run the conversion and drive the result register
	atup_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (pop_valid),
		.tok       (pop_tok),
		.tok_pop   (pop),
		.result    (result)
	);

endmodule

// ===== src/atup_front.sv =====
// Front end: holds the radix register, accepts character words and
// classifies each into a token for the queue. Depends on atup_pkg, atup_if.
module atup_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [atup_pkg::BASE_W-1:0] cfg_wdata,
	atup_in_if.sink                     chars,
	output logic                        push_valid,
	input  logic                        push_ready,
	output atup_pkg::tok_t              push_tok
);
	import atup_pkg::*;

	logic [BASE_W-1:0] radix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RST;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	assign chars.ready = push_ready;
	assign push_valid  = chars.valid;

	always_comb begin
		logic [CH_W-1:0] c;
		logic [CH_W-1:0] d;
		c = chars.ch;
		d = '0;
		push_tok.first    = chars.first;
		push_tok.radix    = radix_q;
		push_tok.is_digit = 1'b1;
		// digit value: 0-9, then letters as 10-35 in either case
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			d = c - CH_ZERO;
		end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
			d = c - UP_OFS;
		end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
			d = c - LO_OFS;
		end else begin
			push_tok.is_digit = 1'b0;
		end
		push_tok.dval = d[DIG_W-1:0];

		if (c inside {CH_SPACE, CH_TAB, CH_LF}) begin
			push_tok.cls = CLS_SPACE;
		end else if (c == CH_MINUS) begin
			push_tok.cls = CLS_MINUS;
		end else if (c == CH_PLUS) begin
			push_tok.cls = CLS_PLUS;
		end else if (c == CH_ZERO) begin
			push_tok.cls = CLS_ZERO;
		end else if (c inside {CH_UP_X, CH_LO_X}) begin
			push_tok.cls = CLS_X;
		end else if (c inside {CH_UP_B, CH_LO_B}) begin
			push_tok.cls = CLS_B;
		end else begin
			push_tok.cls = CLS_OTHER;
		end
	end

endmodule

// ===== src/atup_fifo.sv =====
// Short token queue between front and back end of the parser.
// Register array with read and write pointers. Depends on atup_pkg.
module atup_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  atup_pkg::tok_t push_tok,
	output logic           pop_valid,
	input  logic           pop,
	output atup_pkg::tok_t pop_tok
);
	import atup_pkg::*;

	tok_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != FCNT_W'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/atup_back.sv =====
// Back end: conversion state machine, multiply-add accumulator and the
// result register. Depends on atup_pkg, atup_if.
module atup_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_valid,
	input  atup_pkg::tok_t tok,
	output logic           tok_pop,
	atup_out_if.source     result
);
	import atup_pkg::*;

	typedef enum logic [2:0] {
		PH_DONE,
		PH_LEAD,
		PH_START,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	phase_t                ph_q;
	logic [VAL_W-1:0]      acc_q;
	logic [BASE_W-1:0]     base_q;
	logic                  neg_q;
	logic                  seen_q;
	logic                  ovf_q;
	logic [POS_WIDTH-1:0]  pos_q;
	logic                  out_valid_q;
	logic [VAL_W-1:0]      out_value_q;
	logic [CNT_W-1:0]      out_cnt_q;
	logic                  out_nod_q;
	logic                  out_ovf_q;

	phase_t                ph_n;
	logic [VAL_W-1:0]      acc_n;
	logic [BASE_W-1:0]     base_n;
	logic                  neg_n;
	logic                  seen_n;
	logic                  ovf_n;
	logic [POS_WIDTH-1:0]  pos_n;
	logic                  fin;
	logic [MUL_W-1:0]      prod;
	logic [VAL_W-1:0]      res_value;
	logic [CNT_W-1:0]      res_cnt;

	// take a token only when the result register is free or being emptied
	assign tok_pop = tok_valid && (!out_valid_q || result.ready);

	always_comb begin
		logic walk;
		logic adv;
		logic take;
		ph_n   = tok.first ? PH_LEAD : ph_q;
		acc_n  = tok.first ? '0 : acc_q;
		base_n = tok.first ? tok.radix : base_q;
		neg_n  = tok.first ? 1'b0 : neg_q;
		seen_n = tok.first ? 1'b0 : seen_q;
		ovf_n  = tok.first ? 1'b0 : ovf_q;
		pos_n  = tok.first ? '0 : pos_q;
		walk   = (ph_n != PH_DONE);
		adv    = 1'b0;
		take   = 1'b0;
		fin    = 1'b0;
		prod   = '0;

		if (walk && ph_n == PH_LEAD) begin
			if (tok.cls == CLS_SPACE) begin
				adv  = 1'b1;
				walk = 1'b0;
			end else if (tok.cls == CLS_MINUS || tok.cls == CLS_PLUS) begin
				neg_n = (tok.cls == CLS_MINUS);
				ph_n  = PH_START;
				adv   = 1'b1;
				walk  = 1'b0;
			end else begin
				ph_n = PH_START;
			end
		end

		if (walk && ph_n == PH_START) begin
			if (tok.cls == CLS_ZERO) begin
				ph_n = PH_ZERO;
				adv  = 1'b1;
				walk = 1'b0;
			end else begin
				if (base_n == BASE_AUTO) begin
					base_n = BASE_DEC;
				end
				ph_n = PH_DIGITS;
			end
		end else if (walk && ph_n == PH_ZERO) begin
			if (tok.cls == CLS_X && (base_n == BASE_AUTO || base_n == BASE_HEX)) begin
				base_n = BASE_HEX;
				ph_n   = PH_DIGITS;
				adv    = 1'b1;
				walk   = 1'b0;
			end else if (tok.cls == CLS_B && (base_n == BASE_AUTO || base_n == BASE_BIN)) begin
				base_n = BASE_BIN;
				ph_n   = PH_DIGITS;
				adv    = 1'b1;
				walk   = 1'b0;
			end else begin
				// the leading zero counts as a digit; accumulator stays zero
				if (base_n == BASE_AUTO) begin
					base_n = BASE_OCT;
				end
				seen_n = 1'b1;
				ph_n   = PH_DIGITS;
			end
		end

		if (walk) begin
			if (!tok.is_digit || BASE_W'(tok.dval) >= base_n) begin
				fin  = 1'b1;
				ph_n = PH_DONE;
			end else begin
				take = 1'b1;
				adv  = 1'b1;
			end
		end

		if (take) begin
			seen_n = 1'b1;
			prod   = MUL_W'(acc_n) * MUL_W'(base_n) + MUL_W'(tok.dval);
			// anything above bit 63 means the value no longer fits
			if (ovf_n || (prod[MUL_W-1:VAL_W] != '0)) begin
				ovf_n = 1'b1;
			end else begin
				acc_n = prod[VAL_W-1:0];
			end
		end

		if (adv && pos_n != '1) begin
			pos_n = pos_n + 1'b1;
		end
	end

	always_comb begin
		if (ovf_n) begin
			res_value = '1;
		end else if (neg_n) begin
			res_value = '0 - acc_n;
		end else begin
			res_value = acc_n;
		end
		if (!seen_n) begin
			res_cnt = '0;
		end else if ((pos_n >> CNT_W) != '0) begin
			res_cnt = '1;
		end else begin
			res_cnt = CNT_W'(pos_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_DONE;
			acc_q       <= '0;
			base_q      <= '0;
			neg_q       <= 1'b0;
			seen_q      <= 1'b0;
			ovf_q       <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_cnt_q   <= '0;
			out_nod_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (tok_pop) begin
				ph_q   <= ph_n;
				acc_q  <= acc_n;
				base_q <= base_n;
				neg_q  <= neg_n;
				seen_q <= seen_n;
				ovf_q  <= ovf_n;
				pos_q  <= pos_n;
				if (fin) begin
					out_valid_q <= 1'b1;
					out_value_q <= res_value;
					out_cnt_q   <= res_cnt;
					out_nod_q   <= !seen_n;
					out_ovf_q   <= ovf_n;
				end
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.value      = out_value_q;
	assign result.consumed   = out_cnt_q;
	assign result.no_digits  = out_nod_q;
	assign result.overflowed = out_ovf_q;

endmodule

// ===== src/atup_checker.sv =====
// Port-level checks for the ASCII-to-unsigned parser, bound to the top
// level. Depends on atup_pkg and ascii_to_unsigned_parser.
module atup_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [atup_pkg::VAL_W-1:0] res_value,
	input logic [atup_pkg::CNT_W-1:0] res_consumed,
	input logic                       res_no_digits,
	input logic                       res_overflowed
);
	import atup_pkg::*;

	// hold a stalled result word
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_value) && $stable(res_consumed)
			&& $stable(res_no_digits) && $stable(res_overflowed))
		else $error("result word changed while stalled");

	// a string without digits reports zero everywhere
	a_no_digits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_no_digits |-> res_value == '0 && res_consumed == '0
			&& !res_overflowed)
		else $error("no-digit result carries a value");

	// overflow saturates and always follows at least one digit
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_overflowed |-> res_value == '1 && !res_no_digits
			&& res_consumed != '0)
		else $error("overflow result not saturated");

endmodule

bind ascii_to_unsigned_parser atup_checker u_atup_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_value      (result.value),
	.res_consumed   (result.consumed),
	.res_no_digits  (result.no_digits),
	.res_overflowed (result.overflowed)
);
